// ===== sv/csl_pkg.sv =====
// Shared types and constants for the C source lexer.
// Used by c_source_lexer, csl_keyword and csl_rsp_queue; no dependencies.
package csl_pkg;

   localparam int          VALUE_W   = 31;
   localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

   localparam int KW_COUNT = 13;
   localparam int KW_MAX   = 6;

   // keyword text, left aligned and padded with blanks to six characters
   localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
      "if    ", "do    ", "for   ", "int   ", "char  ", "case  ", "else  ",
      "float ", "while ", "static", "double", "switch", "printf"
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6
   };

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_NUM  = 2'd1,
      MODE_ID   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      TOK_NUMBER  = 3'd0,
      TOK_ID_CHAR = 3'd1,
      TOK_ID_END  = 3'd2,
      TOK_SPECIAL = 3'd3,
      TOK_SUMMARY = 3'd4
   } kind_type;

   typedef struct packed {
      logic [KW_COUNT-1:0] cand;
      logic [2:0]          pos;
   } kw_state_type;

   typedef struct packed {
      kind_type           kind;
      logic [VALUE_W-1:0] value;
      logic [3:0]         kw;
      logic               sat;
      logic               last;
   } rsp_type;

   // character of a keyword at a position; zero past the padded text
   function automatic logic [7:0] kw_char(input logic [8*KW_MAX-1:0] text,
                                          input logic [2:0] pos);
      logic [8*KW_MAX-1:0] sh;
      sh = text << {pos, 3'b000};
      return sh[8*KW_MAX-1 -: 8];
   endfunction

endpackage

// ===== sv/csl_keyword.sv =====
// Keyword candidate narrowing and final match for identifiers.
// Depends on csl_pkg.
module csl_keyword
   import csl_pkg::*;
(
   input  kw_state_type cur,
   input  logic         restart,
   input  logic [7:0]   in_byte,
   output kw_state_type nxt,
   output logic [3:0]   match_idx
);

   kw_state_type base;

   always_comb begin
      base = restart ? '{cand: '1, pos: 3'd0} : cur;
      nxt.cand = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         nxt.cand[k] = base.cand[k] && (base.pos < KW_LEN[k]) &&
                       (kw_char(KW_TEXT[k], base.pos) == in_byte);
      end
      nxt.pos = (base.pos == 3'd7) ? base.pos : base.pos + 3'd1;
   end

   // first surviving keyword whose length equals characters seen
   always_comb begin
      match_idx = 4'd0;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (cur.cand[k] && KW_LEN[k] == cur.pos) begin
            match_idx = 4'(k + 1);
         end
      end
   end

endmodule

// ===== sv/csl_rsp_queue.sv =====
// Result queue: takes up to two token beats per cycle, drains one per cycle while pop is high.
// Depends on csl_pkg.
module csl_rsp_queue
   import csl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_n,
   input  rsp_type    push_a,
   input  rsp_type    push_b,
   input  logic       pop,
   output rsp_type    head,
   output logic       valid,
   output logic       room
);

   rsp_type              q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] head_ff, head_in;
   logic [RSP_PTR_W:0]   count_ff, count_in;
   logic [RSP_PTR_W-1:0] tail, tail_b;
   logic                 do_pop;

   assign valid  = (count_ff != '0);
   assign room   = (count_ff <= (RSP_PTR_W + 1)'(RSP_DEPTH - 2));
   assign head   = q_ff[head_ff];
   assign do_pop = pop && valid;
   assign tail   = head_ff + count_ff[RSP_PTR_W-1:0];
   assign tail_b = tail + 1'b1;

   always_comb begin
      head_in  = do_pop ? head_ff + 1'b1 : head_ff;
      count_in = count_ff + (RSP_PTR_W + 1)'(push_n) - (RSP_PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_ff[tail] <= push_a;
      end
      if (push_n == 2'd2) begin
         q_ff[tail_b] <= push_b;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (RSP_PTR_W + 1)'(RSP_DEPTH))
      else $error("result queue overfilled");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (do_pop && push_n == 2'd0) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count wrong after pop");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && push_n != 2'd0) |=> valid)
      else $error("pushed beat not visible");

endmodule

// ===== sv/c_source_lexer.sv =====
// Lexer for C-like source text, one byte per beat; top level.
// Depends on csl_pkg, csl_keyword and csl_rsp_queue.
//
// Takes one byte (or an end-of-input beat) every cycle while req_tready is
// high. The token logic sits between the lexer state registers and a
// four-entry result queue, so each byte is handled in the cycle it is taken.
// A byte yields zero, one or two result beats; the result side drains one
// beat per cycle while rsp_tready is high, so a byte that yields two
// results needs two output beats. req_tready is high whenever the queue has
// room for two beats, which holds one byte per cycle while the result side
// keeps up. An end-of-input beat flushes any open token, reports the line
// count and returns all lexer state, line count included, to its reset value.
module c_source_lexer
   import csl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [30:0] token_value, [34:31] keyword_index,
                                    // [35] number_saturated, [39:36] zero
   output logic [2:0]  rsp_tuser,   // [2:0] token_kind
   output logic        rsp_tlast    // last_of_run
);

   mode_type           mode_ff, mode_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               clamped_ff, clamped_in;
   kw_state_type       kw_ff, kw_in, kw_narrow;
   logic [VALUE_W-1:0] line_ff, line_in;

   logic               accept, eoi;
   logic [7:0]         b;
   logic               is_digit, is_letter, is_idchar;
   logic [3:0]         digit_val;
   logic [VALUE_W+3:0] acc_prod;
   logic [3:0]         match_idx;
   logic               open_tok, cont;
   logic               fl_v, sec_v;
   rsp_type            fl, sec, push_a, push_b;
   logic [1:0]         push_n;
   rsp_type            head;

   assign accept    = req_tvalid && req_tready;
   assign eoi       = req_tuser;
   assign b         = req_tdata;
   assign is_digit  = (b >= "0") && (b <= "9");
   assign is_letter = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
   assign is_idchar = is_letter || is_digit || (b == "_") || (b == "$");
   assign digit_val = b[3:0];
   assign open_tok  = (mode_ff == MODE_NUM) || (mode_ff == MODE_ID);

   // acc * 10 + digit
   assign acc_prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                     (VALUE_W + 4)'(digit_val);

   csl_keyword u_keyword (
      .cur       (kw_ff),
      .restart   (mode_ff != MODE_ID),
      .in_byte   (b),
      .nxt       (kw_narrow),
      .match_idx (match_idx)
   );

   always_comb begin
      mode_in    = mode_ff;
      acc_in     = acc_ff;
      clamped_in = clamped_ff;
      kw_in      = kw_ff;
      line_in    = line_ff;
      cont       = 1'b0;
      fl_v       = 1'b0;
      sec_v      = 1'b0;
      sec        = '{kind: TOK_SPECIAL, value: '0, kw: '0, sat: 1'b0, last: 1'b0};

      unique case (mode_ff)
         MODE_NUM: fl = '{kind: TOK_NUMBER, value: acc_ff, kw: '0, sat: clamped_ff,
                          last: 1'b0};
         MODE_ID:  fl = '{kind: TOK_ID_END, value: '0, kw: match_idx, sat: 1'b0,
                          last: 1'b0};
         default:  fl = '{kind: TOK_NUMBER, value: '0, kw: '0, sat: 1'b0, last: 1'b0};
      endcase

      if (accept) begin
         if (eoi) begin
            fl_v       = open_tok;
            sec_v      = 1'b1;
            sec        = '{kind: TOK_SUMMARY, value: line_ff, kw: '0,
                           sat: (line_ff == VALUE_MAX), last: 1'b0};
            mode_in    = MODE_IDLE;
            acc_in     = '0;
            clamped_in = 1'b0;
            kw_in      = '{cand: '1, pos: 3'd0};
            line_in    = '0;
         end else begin
            if (mode_ff == MODE_NUM && is_digit) begin
               cont = 1'b1;
               if (acc_prod[VALUE_W+3:VALUE_W] != '0) begin
                  acc_in     = VALUE_MAX;
                  clamped_in = 1'b1;
               end else begin
                  acc_in = acc_prod[VALUE_W-1:0];
               end
            end else if (mode_ff == MODE_ID && is_idchar) begin
               cont  = 1'b1;
               kw_in = kw_narrow;
               sec_v = 1'b1;
               sec   = '{kind: TOK_ID_CHAR, value: VALUE_W'(b), kw: '0, sat: 1'b0,
                         last: 1'b0};
            end

            if (!cont) begin
               // close any open token, then treat the byte as if idle
               fl_v       = open_tok;
               mode_in    = MODE_IDLE;
               acc_in     = '0;
               clamped_in = 1'b0;
               kw_in      = '{cand: '1, pos: 3'd0};
               priority if (is_digit) begin
                  mode_in = MODE_NUM;
                  acc_in  = VALUE_W'(digit_val);
               end else if (is_letter) begin
                  mode_in = MODE_ID;
                  kw_in   = kw_narrow;
                  sec_v   = 1'b1;
                  sec     = '{kind: TOK_ID_CHAR, value: VALUE_W'(b), kw: '0,
                              sat: 1'b0, last: 1'b0};
               end else if (b == 8'h0A) begin
                  if (line_ff != VALUE_MAX) begin
                     line_in = line_ff + 1'b1;
                  end
               end else if (b == " " || b == 8'h09) begin
                  // whitespace: nothing to report
               end else begin
                  sec_v = 1'b1;
                  sec   = '{kind: TOK_SPECIAL, value: VALUE_W'(b), kw: '0,
                            sat: 1'b0, last: 1'b0};
               end
            end
         end
      end
   end

   // pack the flushed token and the fresh result into up to two queue beats
   always_comb begin
      push_a = fl_v ? fl : sec;
      push_b = sec;
      push_n = 2'(fl_v) + 2'(sec_v);
      push_a.last = !(fl_v && sec_v);
      push_b.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         acc_ff     <= '0;
         clamped_ff <= 1'b0;
         kw_ff      <= '{cand: '1, pos: 3'd0};
         line_ff    <= '0;
      end else begin
         mode_ff    <= mode_in;
         acc_ff     <= acc_in;
         clamped_ff <= clamped_in;
         kw_ff      <= kw_in;
         line_ff    <= line_in;
      end
   end

   csl_rsp_queue u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push_n (push_n),
      .push_a (push_a),
      .push_b (push_b),
      .pop    (rsp_tready),
      .head   (head),
      .valid  (rsp_tvalid),
      .room   (req_tready)
   );

   assign rsp_tdata = {4'b0000, head.sat, head.kw, head.value};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   a_eoi_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && eoi) |=> (line_ff == '0 && mode_ff == MODE_IDLE))
      else $error("end of input did not clear state");

   a_clamp_max: assert property (@(posedge clock) disable iff (reset)
      clamped_ff |-> (acc_ff == VALUE_MAX && mode_ff == MODE_NUM))
      else $error("clamp flag without saturated number");

   a_pos_mode: assert property (@(posedge clock) disable iff (reset)
      (kw_ff.pos != 3'd0) == (mode_ff == MODE_ID))
      else $error("identifier position out of step with mode");

endmodule

// ===== bench/c_source_lexer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for c_source_lexer: directed table, then random token streams.
// Depends on csl_pkg (mode and token kind enums) and the c_source_lexer RTL.
module c_source_lexer_tb
   import csl_pkg::*;
();

   localparam logic [30:0] VALUE_TOP   = 31'h7FFF_FFFF;
   localparam int          KW_TOTAL    = 13;
   localparam int          RANDOM_ITEMS = 1000;
   localparam int          STALL_LIMIT = 2000;
   localparam int          HOLD_CYCLES = 64;

   typedef struct packed {
      kind_type    kind;
      logic [30:0] value;
      logic [3:0]  kw;
      logic        sat;
      logic        last;
   } token_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
      logic [1:0] typed_n;   // nonzero: expected beats typed in below
      token_type  t0;
      token_type  t1;
   } stim_row_type;

   localparam token_type NONE = '0;
   localparam int        DIRECTED_N = 25;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_N] = '{
      '{8'hA5, 1'b1, 2'd1, '{TOK_SUMMARY, 31'd0, 4'd0, 1'b0, 1'b1}, NONE},
      '{8'h00, 1'b0, 2'd1, '{TOK_SPECIAL, 31'd0, 4'd0, 1'b0, 1'b1}, NONE},
      '{8'hFF, 1'b0, 2'd1, '{TOK_SPECIAL, 31'd255, 4'd0, 1'b0, 1'b1}, NONE},
      '{"w", 1'b0, 2'd0, NONE, NONE},
      '{"h", 1'b0, 2'd0, NONE, NONE},
      '{"i", 1'b0, 2'd0, NONE, NONE},
      '{"l", 1'b0, 2'd0, NONE, NONE},
      '{"e", 1'b0, 2'd0, NONE, NONE},
      '{"(", 1'b0, 2'd0, NONE, NONE},
      '{8'h0A, 1'b0, 2'd0, NONE, NONE},
      '{8'h09, 1'b0, 2'd0, NONE, NONE},
      '{" ", 1'b0, 2'd0, NONE, NONE},
      '{"4", 1'b0, 2'd0, NONE, NONE},
      '{"2", 1'b0, 2'd0, NONE, NONE},
      '{"9", 1'b0, 2'd0, NONE, NONE},
      '{"4", 1'b0, 2'd0, NONE, NONE},
      '{"9", 1'b0, 2'd0, NONE, NONE},
      '{"6", 1'b0, 2'd0, NONE, NONE},
      '{"7", 1'b0, 2'd0, NONE, NONE},
      '{"2", 1'b0, 2'd0, NONE, NONE},
      '{"9", 1'b0, 2'd0, NONE, NONE},
      '{"5", 1'b0, 2'd0, NONE, NONE},
      '{";", 1'b0, 2'd2, '{TOK_NUMBER, VALUE_TOP, 4'd0, 1'b1, 1'b0},
                         '{TOK_SPECIAL, 31'h3B, 4'd0, 1'b0, 1'b1}},
      '{"_", 1'b0, 2'd0, NONE, NONE},
      '{8'h3C, 1'b1, 2'd1, '{TOK_SUMMARY, 31'd1, 4'd0, 1'b0, 1'b1}, NONE}
   };

   string keyword_words [KW_TOTAL] = '{
      "if", "do", "for", "int", "char", "case", "else",
      "float", "while", "static", "double", "switch", "printf"
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   c_source_lexer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // lexer state mirror
   mode_type            lex_state;
   logic [30:0]         number_acc;
   logic                number_clamped;
   logic [KW_TOTAL-1:0] kw_alive;
   logic [2:0]          ident_len;
   logic [30:0]         line_count;

   token_type step_tok [2];
   int        step_n;
   token_type expected_tokens [$];

   // what the sender is offering right now, mirrored for the monitor
   logic [1:0] offered_typed_n;
   token_type  offered_typed [2];

   int   error_count;
   int   idle_cycles;
   int   sent_items;
   logic hold_off_request;
   logic sender_rush;
   logic sender_calm;
   int   sender_calm_left;

   function logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function logic is_letter(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function logic is_ident_char(input logic [7:0] b);
      return is_letter(b) || is_digit(b) || b == "_" || b == "$";
   endfunction

   function void add_token(input kind_type kind, input logic [30:0] value,
                           input logic [3:0] kw, input logic sat);
      step_tok[step_n] = '{kind: kind, value: value, kw: kw, sat: sat, last: 1'b0};
      step_n++;
   endfunction

   function void narrow_keywords(input logic [7:0] b);
      for (int k = 0; k < KW_TOTAL; k++)
         if (kw_alive[k] && (ident_len >= keyword_words[k].len() ||
                             keyword_words[k][ident_len] != b))
            kw_alive[k] = 1'b0;
      if (ident_len < 3'd7)
         ident_len++;
   endfunction

   function logic [3:0] keyword_hit();
      for (int k = 0; k < KW_TOTAL; k++)
         if (kw_alive[k] && keyword_words[k].len() == ident_len)
            return 4'(k + 1);
      return 4'd0;
   endfunction

   function void clear_token();
      lex_state      = MODE_IDLE;
      number_acc     = '0;
      number_clamped = 1'b0;
      kw_alive       = '1;
      ident_len      = '0;
   endfunction

   function void close_token();
      if (lex_state == MODE_NUM)
         add_token(TOK_NUMBER, number_acc, 4'd0, number_clamped);
      else if (lex_state == MODE_ID)
         add_token(TOK_ID_END, 31'd0, keyword_hit(), 1'b0);
      clear_token();
   endfunction

   // result beats for one accepted input beat, into step_tok / step_n
   function void lex_predict(input logic [7:0] b, input logic eoi);
      logic [34:0] grown;
      logic        taken;
      step_n = 0;
      taken  = 1'b1;
      if (eoi) begin
         close_token();
         add_token(TOK_SUMMARY, line_count, 4'd0, line_count == VALUE_TOP);
         line_count = '0;
      end else if (lex_state == MODE_NUM && is_digit(b)) begin
         grown = {4'b0, number_acc} * 35'd10 + {27'b0, b - 8'h30};
         if (grown > {4'b0, VALUE_TOP}) begin
            grown          = {4'b0, VALUE_TOP};
            number_clamped = 1'b1;
         end
         number_acc = grown[30:0];
      end else if (lex_state == MODE_ID && is_ident_char(b)) begin
         narrow_keywords(b);
         add_token(TOK_ID_CHAR, {23'b0, b}, 4'd0, 1'b0);
      end else begin
         // terminator of an open token is handled again from idle
         close_token();
         taken = 1'b0;
      end
      if (!taken) begin
         if (is_digit(b)) begin
            lex_state  = MODE_NUM;
            number_acc = {23'b0, b - 8'h30};
         end else if (is_letter(b)) begin
            lex_state = MODE_ID;
            narrow_keywords(b);
            add_token(TOK_ID_CHAR, {23'b0, b}, 4'd0, 1'b0);
         end else if (b == 8'h0A) begin
            if (line_count < VALUE_TOP)
               line_count++;
         end else if (b != " " && b != 8'h09) begin
            add_token(TOK_SPECIAL, {23'b0, b}, 4'd0, 1'b0);
         end
      end
      if (step_n > 0)
         step_tok[step_n-1].last = 1'b1;
   endfunction

   function void compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
         error_count++;
      end
   endfunction

   function void check_token_beat();
      token_type want;
      if (expected_tokens.size() == 0) begin
         $display("%0t: result beat with nothing expected, expected none, %s %0d %0d",
                  $time, "got kind and value", rsp_tuser, rsp_tdata[30:0]);
         error_count++;
      end else begin
         want = expected_tokens.pop_front();
         compare_field("token_kind", 32'(want.kind), 32'(rsp_tuser));
         compare_field("token_value", 32'(want.value), 32'(rsp_tdata[30:0]));
         compare_field("keyword_index", 32'(want.kw), 32'(rsp_tdata[34:31]));
         compare_field("number_saturated", 32'(want.sat), 32'(rsp_tdata[35]));
         compare_field("tdata padding", 32'd0, 32'(rsp_tdata[39:36]));
         compare_field("last_of_run", 32'(want.last), 32'(rsp_tlast));
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // both sides sampled in one place, so a result is never checked before its input is predicted
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= idle_cycles + 1;
      end else begin
         if (req_tvalid && req_tready) begin
            lex_predict(req_tdata, req_tuser);
            if (offered_typed_n != 2'd0) begin
               for (int i = 0; i < offered_typed_n; i++)
                  expected_tokens.push_back(offered_typed[i]);
            end else begin
               for (int i = 0; i < step_n; i++)
                  expected_tokens.push_back(step_tok[i]);
            end
         end
         if (rsp_tvalid && rsp_tready)
            check_token_beat();
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      do @(posedge clock); while (idle_cycles < STALL_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // result side: random stalls, calm stretches, one long hold-off on request
   initial begin
      int   stall;
      int   calm_left;
      logic calm;
      calm_left = 0;
      calm      = 1'b0;
      rsp_tready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (calm_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(20, 80);
         end
         calm_left--;
         stall = calm ? 0 : $urandom_range(0, 3);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic eoi,
                            input logic [1:0] typed_n = 2'd0,
                            input token_type t0 = '0, input token_type t1 = '0);
      int gap;
      if (sender_calm_left == 0) begin
         sender_calm      = ($urandom_range(0, 3) == 0);
         sender_calm_left = $urandom_range(20, 80);
      end
      sender_calm_left--;
      gap = (sender_calm || sender_rush) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid       <= 1'b1;
      req_tdata        <= b;
      req_tuser        <= eoi;
      offered_typed_n  <= typed_n;
      offered_typed[0] <= t0;
      offered_typed[1] <= t1;
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_tokens.size() != 0);
   endtask

   function logic [7:0] random_letter();
      return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                  : 8'("A" + $urandom_range(0, 25));
   endfunction

   function logic [7:0] random_ident_char();
      case ($urandom_range(0, 9))
         6, 7:    return 8'("0" + $urandom_range(0, 9));
         8:       return "_";
         9:       return "$";
         default: return random_letter();
      endcase
   endfunction

   function logic [7:0] random_separator();
      case ($urandom_range(0, 6))
         0:       return " ";
         1:       return 8'h0A;
         2:       return 8'h09;
         3:       return ";";
         4:       return "(";
         5:       return "=";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one well-formed token (mostly) followed by a separator, or noise
   task automatic send_token_group();
      int pick;
      int k;
      int i;
      int digits;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         k = $urandom_range(0, KW_TOTAL - 1);
         for (i = 0; i < keyword_words[k].len(); i++)
            send_beat(keyword_words[k][i], 1'b0);
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) send_beat(random_ident_char(), 1'b0);
         send_beat(random_separator(), 1'b0);
      end else if (pick < 45) begin
         send_beat(random_letter(), 1'b0);
         repeat ($urandom_range(0, 9)) send_beat(random_ident_char(), 1'b0);
         send_beat(random_separator(), 1'b0);
      end else if (pick < 65) begin
         digits = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 13) : $urandom_range(1, 4);
         repeat (digits) send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
         send_beat(random_separator(), 1'b0);
      end else if (pick < 80) begin
         send_beat(random_separator(), 1'b0);
      end else if (pick < 97) begin
         send_beat(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         send_beat(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   initial begin
      logic held;
      logic paused;
      error_count      = 0;
      idle_cycles      = 0;
      sent_items       = 0;
      hold_off_request = 1'b0;
      sender_rush      = 1'b0;
      sender_calm      = 1'b0;
      sender_calm_left = 0;
      held             = 1'b0;
      paused           = 1'b0;
      clear_token();
      line_count = '0;
      reset            <= 1'b1;
      req_tvalid       <= 1'b0;
      req_tdata        <= 8'h00;
      req_tuser        <= 1'b0;
      offered_typed_n  <= 2'd0;
      offered_typed[0] <= '0;
      offered_typed[1] <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_N; r++)
         send_beat(DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].eoi, DIRECTED_ROWS[r].typed_n,
                   DIRECTED_ROWS[r].t0, DIRECTED_ROWS[r].t1);

      while (sent_items < DIRECTED_N + RANDOM_ITEMS) begin
         if (!held && sent_items > 300) begin
            // result side stalls while specials keep coming: queue fills, input backs up
            held             = 1'b1;
            hold_off_request = 1'b1;
            sender_rush      = 1'b1;
            repeat (30) send_beat("+", 1'b0);
            sender_rush = 1'b0;
         end
         if (!paused && sent_items > 650) begin
            paused = 1'b1;
            wait_drained();
         end
         send_token_group();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
